// ===== design/hki_pkg.sv =====
// Shared types and constants for the Hermite keyframe interpolator.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package hki_pkg;

  localparam int KEY_DEPTH_DEF = 64;
  localparam int TIME_W        = 24;
  localparam int VAL_W         = 32;
  localparam int INDEX_W       = 6;
  localparam int QUO_W         = 40;   // |n| * 65536 / |d| fits in 40 bits
  localparam int HMAG_W        = 63;   // magnitude of a Horner term, at most 2^62
  localparam int PROD_W        = QUO_W + HMAG_W;
  localparam int STEP_CNT_W    = 6;

  localparam logic [TIME_W-1:0] END_TIME = 24'hFFFF00;
  localparam logic [HMAG_W-1:0] LIM62    = 63'h4000_0000_0000_0000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]       key_time;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] in_slope;
    logic signed [VAL_W-1:0] out_slope;
  } key_t;

  typedef struct packed {
    logic                 en;
    logic [INDEX_W-1:0]   index;
    key_t                 key;
  } wr_t;

  // Search token that walks down the row of key cells.
  // While searching, a is the key two back and b the key one back;
  // once done, a and b are the start and end keys of the segment.
  typedef struct packed {
    logic              valid;
    logic              done;
    logic              direct;
    logic [TIME_W-1:0] q;
    key_t              a;
    key_t              b;
  } token_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_DM0,
    ST_DM1,
    ST_COEF,
    ST_DIV,
    ST_MSTART,
    ST_MWAIT,
    ST_MACC,
    ST_FIN
  } state_t;

endpackage

// ===== design/hermite_keyframe_interpolator.sv =====
// Top level of the Hermite keyframe interpolator: key cell row, sequencer, datapath.
// Depends on hki_pkg, hki_cell, hki_divider and hki_multiplier.
`timescale 1ns / 1ps

// Usage.
// The input channel (in_valid / in_ready) carries two kinds of item. A write item
// (in_cmd = 0) loads one keyframe into entry in_key_index and produces no result;
// the entry is usable by the next item. An evaluate item (in_cmd = 1) produces
// one result item on the output channel (out_valid / out_ready) holding the curve
// value at in_query_time. Each key lives in its own cell; a search token moves one
// cell per cycle down the row to find the segment. The segment math then runs on
// a 40-step serial divider and three 40-step passes of a serial multiplier; a query
// before the first key or a zero-length segment skips it. The next item can be
// taken once the result is loaded into the output register. The block works
// on one evaluate item at a time; in_ready is high only while it is idle.
// Results sit in an output register: a stalled receiver does not block the next
// item, but a further result waits until the register is free.
// Reset clears all control state; the keyframe table is not cleared and must be
// written before it is read.

module hermite_keyframe_interpolator #(
  parameter int KEY_DEPTH = hki_pkg::KEY_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [hki_pkg::INDEX_W-1:0]          in_key_index,
  input  logic [hki_pkg::TIME_W-1:0]           in_key_time,
  input  logic signed [hki_pkg::VAL_W-1:0]     in_key_value,
  input  logic signed [hki_pkg::VAL_W-1:0]     in_key_in_slope,
  input  logic signed [hki_pkg::VAL_W-1:0]     in_key_out_slope,
  input  logic [hki_pkg::TIME_W-1:0]           in_query_time,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hki_pkg::VAL_W-1:0]     out_curve_value
);

  localparam int TW = hki_pkg::TIME_W;

  hki_pkg::state_t state_r, state_nxt;

  hki_pkg::wr_t    wr;
  hki_pkg::token_t tok_first;
  hki_pkg::token_t tok [KEY_DEPTH+1];
  hki_pkg::token_t tok_last;

  logic in_acc;

  // Segment registers.
  hki_pkg::key_t             seg_p_r, seg_f_r;
  logic [TW-1:0]             q_r;
  logic signed [TW:0]        d_r, n_r;
  logic signed [63:0]        dm0_r, dm1_r, c2_r, h_r, mq_r;
  logic                      u_neg_r;
  logic [hki_pkg::QUO_W-1:0] u_mag_r;
  logic [1:0]                hk_r;
  logic signed [31:0]        res_r;
  logic                      out_valid_r;
  logic signed [31:0]        out_value_r;

  // Control outputs of the sequencer.
  logic div_start, mul_start, out_load;

  // Divider and multiplier connections.
  logic [TW-1:0]                d_mag, n_mag;
  logic [hki_pkg::QUO_W-1:0]    quo;
  logic                         div_done;
  logic [hki_pkg::HMAG_W-1:0]   h_mag;
  logic [hki_pkg::PROD_W-1:0]   prod;
  logic                         mul_done;
  logic                         m_neg;

  // Datapath intermediates.
  logic signed [56:0]           dmul;
  logic signed [63:0]           dv64, c3, addend, acc_sum, r_shift;
  logic [hki_pkg::HMAG_W-1:0]   mq_mag;
  logic signed [63:0]           mq_val;

  assign in_acc = in_valid && in_ready;

  // Write port broadcast to every cell.
  always_comb begin
    wr.en                = in_acc && (in_cmd == hki_pkg::CMD_WRITE);
    wr.index             = in_key_index;
    wr.key.key_time      = in_key_time;
    wr.key.value         = in_key_value;
    wr.key.in_slope      = in_key_in_slope;
    wr.key.out_slope     = in_key_out_slope;
  end

  // A new token enters the first cell when an evaluate item is taken.
  always_comb begin
    tok_first        = '0;
    tok_first.valid  = in_acc && (in_cmd == hki_pkg::CMD_EVAL);
    tok_first.q      = in_query_time;
  end

  assign tok[0] = tok_first;

  for (genvar i = 0; i < KEY_DEPTH; i++) begin : g_cell
    hki_cell #(
      .CELL_IDX  (i),
      .KEY_DEPTH (KEY_DEPTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tok_last = tok[KEY_DEPTH];

  // Magnitudes for the divider: u = n * 65536 / d, truncated toward zero.
  assign d_mag = d_r[TW] ? TW'(-d_r) : d_r[TW-1:0];
  assign n_mag = n_r[TW] ? TW'(-n_r) : n_r[TW-1:0];

  hki_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({n_mag, 16'h0000}),
    .divisor  (d_mag),
    .quotient (quo),
    .done     (div_done)
  );

  assign h_mag = h_r[63] ? hki_pkg::HMAG_W'(-h_r) : h_r[hki_pkg::HMAG_W-1:0];
  assign m_neg = u_neg_r ^ h_r[63];

  hki_multiplier u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mag_a   (u_mag_r),
    .mag_b   (h_mag),
    .product (prod),
    .done    (mul_done)
  );

  // Scaled product u*h / 65536: floor for positive, rounded away for negative,
  // magnitude clamped to 2^62.
  always_comb begin
    mq_mag = {1'b0, prod[77:16]} + hki_pkg::HMAG_W'(m_neg && (prod[15:0] != '0));
    if ((prod[hki_pkg::PROD_W-1:78] != '0) || (mq_mag > hki_pkg::LIM62)) begin
      mq_mag = hki_pkg::LIM62;
    end
    mq_val = m_neg ? -$signed({1'b0, mq_mag}) : $signed({1'b0, mq_mag});
  end

  // Shared slope multiplier: d times the outgoing slope, then the incoming slope.
  always_comb begin
    if (state_r == hki_pkg::ST_DM0) begin
      dmul = d_r * seg_p_r.out_slope;
    end else begin
      dmul = d_r * seg_f_r.in_slope;
    end
  end

  always_comb begin
    dv64 = 64'(seg_f_r.value) - 64'(seg_p_r.value);
    c3   = (dv64 * -64'sd512) + dm0_r + dm1_r;
    unique case (hk_r)
      2'd0:    addend = c2_r;
      2'd1:    addend = dm0_r;
      default: addend = 64'(seg_p_r.value) * 64'sd256;
    endcase
    acc_sum = addend + mq_r;
    r_shift = (acc_sum + 64'sd128) >>> 8;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hki_pkg::ST_IDLE:
        if (in_acc && (in_cmd == hki_pkg::CMD_EVAL)) state_nxt = hki_pkg::ST_SCAN;
      hki_pkg::ST_SCAN:
        if (tok_last.valid) begin
          state_nxt = tok_last.direct ? hki_pkg::ST_FIN : hki_pkg::ST_SETUP;
        end
      hki_pkg::ST_SETUP:
        state_nxt = hki_pkg::ST_DM0;
      hki_pkg::ST_DM0:
        state_nxt = (d_r == '0) ? hki_pkg::ST_FIN : hki_pkg::ST_DM1;
      hki_pkg::ST_DM1:
        state_nxt = hki_pkg::ST_COEF;
      hki_pkg::ST_COEF:
        state_nxt = hki_pkg::ST_DIV;
      hki_pkg::ST_DIV:
        if (div_done) state_nxt = hki_pkg::ST_MSTART;
      hki_pkg::ST_MSTART:
        state_nxt = hki_pkg::ST_MWAIT;
      hki_pkg::ST_MWAIT:
        if (mul_done) state_nxt = hki_pkg::ST_MACC;
      hki_pkg::ST_MACC:
        state_nxt = (hk_r == 2'd2) ? hki_pkg::ST_FIN : hki_pkg::ST_MSTART;
      hki_pkg::ST_FIN:
        if (!out_valid_r || out_ready) state_nxt = hki_pkg::ST_IDLE;
      default:
        state_nxt = hki_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = (state_r == hki_pkg::ST_IDLE);
    div_start = (state_r == hki_pkg::ST_DM0) && (d_r != '0);
    mul_start = (state_r == hki_pkg::ST_MSTART);
    out_load  = (state_r == hki_pkg::ST_FIN) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hki_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (out_valid_r && !out_ready) || out_load;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r <= in_query_time;
    end
    if (out_load) begin
      out_value_r <= res_r;
    end
    unique case (state_r)
      hki_pkg::ST_SCAN:
        if (tok_last.valid) begin
          seg_p_r <= tok_last.a;
          seg_f_r <= tok_last.b;
          res_r   <= tok_last.b.value;
        end
      hki_pkg::ST_SETUP: begin
        d_r <= $signed({1'b0, seg_f_r.key_time}) - $signed({1'b0, seg_p_r.key_time});
        n_r <= $signed({1'b0, q_r}) - $signed({1'b0, seg_p_r.key_time});
      end
      hki_pkg::ST_DM0: begin
        res_r <= seg_f_r.value;
        dm0_r <= 64'(dmul);
      end
      hki_pkg::ST_DM1:
        dm1_r <= 64'(dmul);
      hki_pkg::ST_COEF: begin
        c2_r <= (dv64 * 64'sd768) - (dm0_r * 64'sd2) - dm1_r;
        h_r  <= c3;
        hk_r <= 2'd0;
      end
      hki_pkg::ST_DIV:
        if (div_done) begin
          u_mag_r <= quo;
          u_neg_r <= n_r[TW] ^ d_r[TW];
        end
      hki_pkg::ST_MWAIT:
        if (mul_done) mq_r <= mq_val;
      hki_pkg::ST_MACC: begin
        hk_r <= hk_r + 2'd1;
        if (acc_sum > $signed({1'b0, hki_pkg::LIM62})) begin
          h_r <= $signed({1'b0, hki_pkg::LIM62});
        end else if (acc_sum < -$signed({1'b0, hki_pkg::LIM62})) begin
          h_r <= -$signed({1'b0, hki_pkg::LIM62});
        end else begin
          h_r <= acc_sum;
        end
        if (r_shift > 64'sd2147483647) begin
          res_r <= 32'sh7FFF_FFFF;
        end else if (r_shift < -64'sd2147483648) begin
          res_r <= 32'sh8000_0000;
        end else begin
          res_r <= r_shift[31:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_curve_value = out_value_r;

  // A token leaves the cell row only while the sequencer waits for it.
  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.valid |-> (state_r == hki_pkg::ST_SCAN))
    else $error("search token left the cell row outside the scan");

  // The divider finishes only while its quotient is awaited.
  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == hki_pkg::ST_DIV))
    else $error("divider finished outside the divide wait");

  // A finished result reaches the output register on the next edge.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && (out_curve_value == $past(res_r))))
    else $error("loaded result not presented");

endmodule

// ===== design/hki_cell.sv =====
// One key cell: stores one keyframe and advances the search token by one step.
// Depends on hki_pkg for key, write and token types.
`timescale 1ns / 1ps

module hki_cell #(
  parameter int CELL_IDX  = 0,
  parameter int KEY_DEPTH = hki_pkg::KEY_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hki_pkg::wr_t    wr,
  input  hki_pkg::token_t tok_in,
  output hki_pkg::token_t tok_out
);

  localparam bit IS_FIRST  = (CELL_IDX == 0);
  localparam bit IS_LAST   = (CELL_IDX == KEY_DEPTH - 1);
  localparam bit STEP_BACK = (CELL_IDX > 1);

  hki_pkg::key_t   key_r;
  hki_pkg::token_t tok_r;
  hki_pkg::token_t tok_nxt;

  logic q_le, is_end, hold;

  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.index) == 32'(CELL_IDX))) begin
      key_r <= wr.key;
    end
  end

  always_comb begin
    q_le    = (tok_in.q <= key_r.key_time);
    is_end  = (key_r.key_time == hki_pkg::END_TIME);
    // Passing the end key beyond entry one keeps the two keys before it.
    hold    = is_end && !q_le && STEP_BACK;
    tok_nxt = tok_in;
    if (IS_FIRST) begin
      tok_nxt.done   = (tok_in.q < key_r.key_time);
      tok_nxt.direct = (tok_in.q < key_r.key_time);
      tok_nxt.a      = tok_in.b;
      tok_nxt.b      = key_r;
    end else if (!tok_in.done) begin
      tok_nxt.done = q_le || is_end || IS_LAST;
      if (!hold) begin
        tok_nxt.a = tok_in.b;
        tok_nxt.b = key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.done   <= tok_nxt.done;
    tok_r.direct <= tok_nxt.direct;
    tok_r.q      <= tok_nxt.q;
    tok_r.a      <= tok_nxt.a;
    tok_r.b      <= tok_nxt.b;
  end

  assign tok_out = tok_r;

endmodule

// ===== design/hki_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on hki_pkg for widths.
`timescale 1ns / 1ps

module hki_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hki_pkg::QUO_W-1:0]    dividend,
  input  logic [hki_pkg::TIME_W-1:0]   divisor,
  output logic [hki_pkg::QUO_W-1:0]    quotient,
  output logic                         done
);

  localparam int W = hki_pkg::TIME_W;

  logic [W-1:0]                      rem_r;
  logic [hki_pkg::QUO_W-1:0]         quo_r;
  logic [W-1:0]                      divs_r;
  logic [hki_pkg::STEP_CNT_W-1:0]    cnt_r;
  logic                              busy_r, done_r;
  logic [W:0]                        sh;
  logic [W+1:0]                      diff;

  always_comb begin
    sh   = {rem_r, quo_r[hki_pkg::QUO_W-1]};
    diff = {1'b0, sh} - {2'b00, divs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == hki_pkg::STEP_CNT_W'(hki_pkg::QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      divs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[W+1]) begin
        rem_r <= diff[W-1:0];
      end else begin
        rem_r <= sh[W-1:0];
      end
      quo_r <= {quo_r[hki_pkg::QUO_W-2:0], !diff[W+1]};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== design/hki_multiplier.sv =====
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Depends on hki_pkg for widths.
`timescale 1ns / 1ps

module hki_multiplier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hki_pkg::QUO_W-1:0]     mag_a,
  input  logic [hki_pkg::HMAG_W-1:0]    mag_b,
  output logic [hki_pkg::PROD_W-1:0]    product,
  output logic                          done
);

  localparam int AW = hki_pkg::QUO_W;
  localparam int BW = hki_pkg::HMAG_W;

  logic [hki_pkg::PROD_W-1:0]       acc_r;
  logic [BW-1:0]                    mb_r;
  logic [hki_pkg::STEP_CNT_W-1:0]   cnt_r;
  logic                             busy_r, done_r;
  logic [BW:0]                      tmp;

  always_comb begin
    tmp = {1'b0, acc_r[hki_pkg::PROD_W-1:AW]} + (acc_r[0] ? {1'b0, mb_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == hki_pkg::STEP_CNT_W'(AW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= {{BW{1'b0}}, mag_a};
      mb_r  <= mag_b;
    end else if (busy_r) begin
      acc_r <= {tmp, acc_r[AW-1:1]};
    end
  end

  assign product = acc_r;
  assign done    = done_r;

endmodule
